>>> hw/rtl/imubc_pkg.sv
// ----------------------------------------------------------------------------
// IMU bias calibration package
// Shared widths, request codes, reciprocal divide constants and the
// structs passed between the core, the divide unit and the top level.
// ----------------------------------------------------------------------------
package imubc_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int SUM_W          = 24;
    localparam int CNT_W          = 8;
    localparam int REQ_W          = 2;
    localparam int NUM_AXES       = 3;
    localparam int ACCEL_SUM_AXES = 2;

    // Number of samples averaged per calibration (2 to 255).
    localparam int CALIB_SAMPLES  = 200;

    // Truncating divide by CALIB_SAMPLES as (|sum| * RECIP) >> DIV_SHIFT.
    // With DIV_SHIFT = SUM_W + clog2(d) the rounding error of the reciprocal
    // stays below one quotient step for every SUM_W-bit magnitude.
    localparam int DIV_SHIFT = SUM_W + $clog2(CALIB_SAMPLES);
    localparam int RECIP_W   = SUM_W + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam int QUOT_W    = PROD_W - DIV_SHIFT;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << DIV_SHIFT) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    typedef enum logic [REQ_W-1:0] {
        REQ_SAMPLE        = 2'd0,
        REQ_GYRO_RESTART  = 2'd1,
        REQ_ACCEL_RESTART = 2'd2
    } req_t;

    typedef enum logic {
        DIV_GYRO  = 1'b0,
        DIV_ACCEL = 1'b1
    } div_sel_t;

    typedef logic [NUM_AXES-1:0][SAMPLE_W-1:0] axis_vec_t;
    typedef logic [NUM_AXES-1:0][SUM_W-1:0]    sum_vec_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        axis_vec_t        accel;
        axis_vec_t        gyro;
    } item_t;

    typedef struct packed {
        axis_vec_t accel;
        axis_vec_t gyro;
        logic      gyro_ready;
        logic      accel_ready;
        logic      gyro_done;
        logic      accel_done;
    } result_t;

    typedef struct packed {
        logic     start;
        div_sel_t sel;
    } div_req_t;

    typedef struct packed {
        logic      wr;
        div_sel_t  sel;
        axis_vec_t offset;
    } div_wr_t;

endpackage

>>> hw/rtl/imubc_div.sv
// ----------------------------------------------------------------------------
// IMU bias calibration: offset divide unit
// Three lanes dividing the calibration sums by CALIB_SAMPLES, truncated
// toward zero, by reciprocal multiply. Offsets appear in the cycle after start.
// ----------------------------------------------------------------------------
module imubc_div (
    input  logic                clk,
    input  logic                rst_n,
    input  imubc_pkg::div_req_t req,
    input  imubc_pkg::sum_vec_t sums,
    output imubc_pkg::div_wr_t  wr
);
    import imubc_pkg::*;

    logic                v_reg;
    div_sel_t            sel_reg;
    logic [NUM_AXES-1:0] neg_reg;
    logic [PROD_W-1:0]   prod_reg [NUM_AXES];

    logic [SUM_W-1:0]    mag  [NUM_AXES];
    logic [QUOT_W-1:0]   quot [NUM_AXES];
    logic [QUOT_W-1:0]   sq   [NUM_AXES];

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            mag[i] = sums[i][SUM_W-1] ? (~sums[i] + 1'b1) : sums[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= 1'b0;
            sel_reg <= DIV_GYRO;
        end
        else
        begin
            v_reg <= req.start;
            if (req.start)
            begin
                sel_reg <= req.sel;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                prod_reg[i] <= PROD_W'(mag[i]) * PROD_W'(RECIP);
                neg_reg[i]  <= sums[i][SUM_W-1];
            end
        end
    end

    // Restore the sign after the magnitude divide.
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            quot[i] = prod_reg[i][PROD_W-1:DIV_SHIFT];
            sq[i]   = neg_reg[i] ? (~quot[i] + 1'b1) : quot[i];
            wr.offset[i] = sq[i][SAMPLE_W-1:0];
        end
        wr.wr  = v_reg;
        wr.sel = sel_reg;
    end

endmodule

>>> hw/rtl/imubc_core.sv
// ----------------------------------------------------------------------------
// IMU bias calibration: correction and accumulation core
// Subtracts the stored offsets, runs the gyro and accel calibration counters
// and sums, and hands finished sums to the divide unit.
// ----------------------------------------------------------------------------
module imubc_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  imubc_pkg::item_t    item,
    output imubc_pkg::result_t  result,
    output logic                busy,
    output imubc_pkg::div_req_t div_req,
    output imubc_pkg::sum_vec_t div_sums,
    input  imubc_pkg::div_wr_t  div_wr
);
    import imubc_pkg::*;

    axis_vec_t                             gyro_offset_reg,  gyro_offset_next;
    axis_vec_t                             accel_offset_reg, accel_offset_next;
    sum_vec_t                              gyro_sum_reg,     gyro_sum_next;
    logic [ACCEL_SUM_AXES-1:0][SUM_W-1:0]  accel_sum_reg,    accel_sum_next;
    logic [CNT_W-1:0]                      gyro_count_reg,   gyro_count_next;
    logic [CNT_W-1:0]                      accel_count_reg,  accel_count_next;
    logic                                  gyro_valid_reg,   gyro_valid_next;
    logic                                  accel_valid_reg,  accel_valid_next;
    logic                                  div_start_reg,    div_start_next;
    div_sel_t                              div_sel_reg,      div_sel_next;

    axis_vec_t acc_corr;
    axis_vec_t gyr_corr;
    logic      g_clear, g_acc, g_finish, g_stop;
    logic      a_clear, a_acc, a_finish;

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            acc_corr[i] = item.accel[i] - accel_offset_reg[i];
            gyr_corr[i] = item.gyro[i] - gyro_offset_reg[i];
        end

        g_clear  = !gyro_valid_reg && (gyro_count_reg == '0);
        g_acc    = !gyro_valid_reg && (gyro_count_reg != '0);
        g_finish = g_acc && (gyro_count_reg >= CNT_W'(CALIB_SAMPLES));
        // The gyro clearing and finishing steps end the step for accel.
        g_stop   = g_clear || g_finish;
        a_clear  = !g_stop && !accel_valid_reg && (accel_count_reg == '0);
        a_acc    = !g_stop && !accel_valid_reg && (accel_count_reg != '0);
        a_finish = a_acc && (accel_count_reg >= CNT_W'(CALIB_SAMPLES));
    end

    always_comb
    begin
        gyro_offset_next  = gyro_offset_reg;
        accel_offset_next = accel_offset_reg;
        gyro_sum_next     = gyro_sum_reg;
        accel_sum_next    = accel_sum_reg;
        gyro_count_next   = gyro_count_reg;
        accel_count_next  = accel_count_reg;
        gyro_valid_next   = gyro_valid_reg;
        accel_valid_next  = accel_valid_reg;
        div_start_next    = 1'b0;
        div_sel_next      = div_sel_reg;

        if (fire)
        begin
            case (item.req)
                REQ_GYRO_RESTART:
                begin
                    gyro_valid_next = 1'b0;
                    gyro_count_next = '0;
                end
                REQ_ACCEL_RESTART:
                begin
                    accel_valid_next = 1'b0;
                    accel_count_next = '0;
                end
                REQ_SAMPLE:
                begin
                    if (g_clear)
                    begin
                        gyro_offset_next = '0;
                        gyro_sum_next    = '0;
                        gyro_count_next  = CNT_W'(1);
                    end
                    else if (g_acc)
                    begin
                        for (int i = 0; i < NUM_AXES; i++)
                        begin
                            gyro_sum_next[i] = gyro_sum_reg[i] +
                                {{(SUM_W-SAMPLE_W){gyr_corr[i][SAMPLE_W-1]}}, gyr_corr[i]};
                        end
                        if (g_finish)
                        begin
                            gyro_count_next = '0;
                            gyro_valid_next = 1'b1;
                            div_start_next  = 1'b1;
                            div_sel_next    = DIV_GYRO;
                        end
                        else
                        begin
                            gyro_count_next = gyro_count_reg + 1'b1;
                        end
                    end

                    if (a_clear)
                    begin
                        accel_offset_next = '0;
                        accel_sum_next    = '0;
                        accel_count_next  = CNT_W'(1);
                    end
                    else if (a_acc)
                    begin
                        // Z is not summed, so its offset comes out zero.
                        for (int i = 0; i < ACCEL_SUM_AXES; i++)
                        begin
                            accel_sum_next[i] = accel_sum_reg[i] +
                                {{(SUM_W-SAMPLE_W){acc_corr[i][SAMPLE_W-1]}}, acc_corr[i]};
                        end
                        if (a_finish)
                        begin
                            accel_count_next = '0;
                            accel_valid_next = 1'b1;
                            div_start_next   = 1'b1;
                            div_sel_next     = DIV_ACCEL;
                        end
                        else
                        begin
                            accel_count_next = accel_count_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (div_wr.wr)
        begin
            if (div_wr.sel == DIV_GYRO)
            begin
                gyro_offset_next = div_wr.offset;
            end
            else
            begin
                accel_offset_next = div_wr.offset;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_offset_reg  <= '0;
            accel_offset_reg <= '0;
            gyro_sum_reg     <= '0;
            accel_sum_reg    <= '0;
            gyro_count_reg   <= '0;
            accel_count_reg  <= '0;
            gyro_valid_reg   <= 1'b0;
            accel_valid_reg  <= 1'b0;
            div_start_reg    <= 1'b0;
            div_sel_reg      <= DIV_GYRO;
        end
        else
        begin
            gyro_offset_reg  <= gyro_offset_next;
            accel_offset_reg <= accel_offset_next;
            gyro_sum_reg     <= gyro_sum_next;
            accel_sum_reg    <= accel_sum_next;
            gyro_count_reg   <= gyro_count_next;
            accel_count_reg  <= accel_count_next;
            gyro_valid_reg   <= gyro_valid_next;
            accel_valid_reg  <= accel_valid_next;
            div_start_reg    <= div_start_next;
            div_sel_reg      <= div_sel_next;
        end
    end

    always_comb
    begin
        result.accel       = acc_corr;
        result.gyro        = gyr_corr;
        result.gyro_ready  = gyro_valid_next;
        result.accel_ready = accel_valid_next;
        result.gyro_done   = g_finish;
        result.accel_done  = a_finish;

        busy          = div_start_reg || div_wr.wr;
        div_req.start = div_start_reg;
        div_req.sel   = div_sel_reg;
        if (div_sel_reg == DIV_GYRO)
        begin
            div_sums = gyro_sum_reg;
        end
        else
        begin
            div_sums = {SUM_W'(0), accel_sum_reg[1], accel_sum_reg[0]};
        end
    end

    a_gyro_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        gyro_count_reg <= CNT_W'(CALIB_SAMPLES))
        else $error("gyro sample count past calibration length");

    a_gyro_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
        gyro_valid_reg |-> (gyro_count_reg == '0))
        else $error("gyro count running while offsets valid");

    a_div_writeback: assert property (@(posedge clk) disable iff (!rst_n)
        div_start_reg |=> div_wr.wr)
        else $error("divide unit missed offset writeback");

    a_no_fire_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !fire)
        else $error("beat processed while offsets being computed");

endmodule

>>> hw/rtl/imu_bias_calibrate_and_correct.sv
// ----------------------------------------------------------------------------
// IMU bias calibrate and correct
// Input register, correction core, offset divide unit and result register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one beat per sensor sample or
//   request: req_type selects a sample, a gyro calibration restart or an accel
//   calibration restart; the six raw readings ride along.
//   Output channel (out_valid / out_stall) carries one beat per sample beat:
//   the six offset-corrected readings plus ready flags and done pulses.
//   Request beats and unknown request codes produce no output beat.
// Timing:
//   An accepted beat is processed from the input register and its result is
//   registered in the output register. Throughput is one beat per cycle
//   unless out_stall or the divide unit holds it. When a calibration finishes,
//   the sums go through the reciprocal multiply divide unit (multiply, then
//   sign fixup), and processing holds until the new offsets are written.
// Reset:
//   rst_n clears offsets, sums, counters and flags, so both calibrations
//   start on the first sample beats after reset.
// Stalls:
//   While out_stall holds a waiting result, one more beat waits in the input
//   register; after that in_stall rises and both payloads hold.
// ----------------------------------------------------------------------------
module imu_bias_calibrate_and_correct (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [imubc_pkg::REQ_W-1:0]         req_type,
    input  logic signed [imubc_pkg::SAMPLE_W-1:0] accel_x_raw,
    input  logic signed [imubc_pkg::SAMPLE_W-1:0] accel_y_raw,
    input  logic signed [imubc_pkg::SAMPLE_W-1:0] accel_z_raw,
    input  logic signed [imubc_pkg::SAMPLE_W-1:0] gyro_x_raw,
    input  logic signed [imubc_pkg::SAMPLE_W-1:0] gyro_y_raw,
    input  logic signed [imubc_pkg::SAMPLE_W-1:0] gyro_z_raw,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [imubc_pkg::SAMPLE_W-1:0] accel_x_out,
    output logic signed [imubc_pkg::SAMPLE_W-1:0] accel_y_out,
    output logic signed [imubc_pkg::SAMPLE_W-1:0] accel_z_out,
    output logic signed [imubc_pkg::SAMPLE_W-1:0] gyro_x_out,
    output logic signed [imubc_pkg::SAMPLE_W-1:0] gyro_y_out,
    output logic signed [imubc_pkg::SAMPLE_W-1:0] gyro_z_out,
    output logic                                gyro_ready,
    output logic                                accel_ready,
    output logic                                gyro_done,
    output logic                                accel_done
);
    import imubc_pkg::*;

    logic     s1_valid_reg, s1_valid_next;
    item_t    s1_item_reg;
    logic     out_valid_reg, out_valid_next;
    result_t  out_result_reg;

    item_t    in_item;
    result_t  core_result;
    logic     core_busy;
    div_req_t div_req;
    sum_vec_t div_sums;
    div_wr_t  div_wr;

    logic     in_accept, s1_fire, out_open, out_load;

    always_comb
    begin
        in_item.req      = req_type;
        in_item.accel[0] = accel_x_raw;
        in_item.accel[1] = accel_y_raw;
        in_item.accel[2] = accel_z_raw;
        in_item.gyro[0]  = gyro_x_raw;
        in_item.gyro[1]  = gyro_y_raw;
        in_item.gyro[2]  = gyro_z_raw;

        out_open       = !out_valid_reg || !out_stall;
        s1_fire        = s1_valid_reg && out_open && !core_busy;
        in_stall       = s1_valid_reg && !s1_fire;
        in_accept      = in_valid && !in_stall;
        out_load       = s1_fire && (s1_item_reg.req == REQ_SAMPLE);
        s1_valid_next  = in_accept || (s1_valid_reg && !s1_fire);
        out_valid_next = out_open ? out_load : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg <= in_item;
        end
        if (out_load)
        begin
            out_result_reg <= core_result;
        end
    end

    imubc_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (s1_fire),
        .item     (s1_item_reg),
        .result   (core_result),
        .busy     (core_busy),
        .div_req  (div_req),
        .div_sums (div_sums),
        .div_wr   (div_wr)
    );

    imubc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .sums  (div_sums),
        .wr    (div_wr)
    );

    assign out_valid   = out_valid_reg;
    assign accel_x_out = out_result_reg.accel[0];
    assign accel_y_out = out_result_reg.accel[1];
    assign accel_z_out = out_result_reg.accel[2];
    assign gyro_x_out  = out_result_reg.gyro[0];
    assign gyro_y_out  = out_result_reg.gyro[1];
    assign gyro_z_out  = out_result_reg.gyro[2];
    assign gyro_ready  = out_result_reg.gyro_ready;
    assign accel_ready = out_result_reg.accel_ready;
    assign gyro_done   = out_result_reg.gyro_done;
    assign accel_done  = out_result_reg.accel_done;

endmodule
